// ===== hdl/pap_pkg.sv =====
// ----------------------------------------------------------------------------
// pap_pkg
// Shared types, micro-operation codes and saturation helpers for the
// point attractor particle step core.
// ----------------------------------------------------------------------------
`default_nettype none

package pap_pkg;

  localparam int MAG_W   = 62;   // magnitude width of every saturated product
  localparam int PROD_W  = 97;   // 64 x 33 bit product
  localparam int FRIC_W  = 16;   // friction is always Q1.16
  localparam int SLOT_EW = 9;    // slot number widened to compare with the depth

  typedef struct packed {
    logic               mode;
    logic [3:0]         slot;
    logic               slot_enable;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] body_mass;
    logic [31:0]        inv_elapsed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } out_item_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [4:0] {
    OP_DIFF, OP_SQX, OP_SQY, OP_SQRT, OP_K1, OP_K2,
    OP_AX, OP_DX1, OP_DX2, OP_DX3, OP_VX,
    OP_AY, OP_DY1, OP_DY2, OP_DY3, OP_VY,
    OP_FX, OP_FY, OP_PX, OP_PY
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_ISSUE, ST_WAIT, ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic start;
    op_e  op;
    logic idx_clr;
    logic idx_inc;
    logic publish;
  } pap_cmd_t;

  typedef struct packed {
    logic done;
    logic near;
    logic cur_valid;
    logic idx_last;
  } pap_sts_t;

  function automatic logic [MAG_W-1:0] sat62(logic [PROD_W-1:0] x);
    logic [MAG_W-1:0] res;
    if (|x[PROD_W-1:MAG_W]) res = '1;
    else res = x[MAG_W-1:0];
    return res;
  endfunction

  function automatic logic signed [MAG_W:0] apply_sign(logic [MAG_W-1:0] m, logic neg);
    logic signed [MAG_W:0] v;
    v = $signed({1'b0, m});
    if (neg) v = -v;
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) res = 32'sh7fffffff;
    else if (v < -64'sd2147483648) res = 32'sh80000000;
    else res = v[31:0];
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pap_ram.sv =====
// ----------------------------------------------------------------------------
// pap_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/pap_ctrl.sv =====
// ----------------------------------------------------------------------------
// pap_ctrl
// Sequencer: accepts transactions, walks the attractor table and steps
// the datapath through its micro-operations for each valid slot.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_mode_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pap_pkg::pap_cmd_t      cmd_o,
  input  wire pap_pkg::pap_sts_t sts_i
);
  import pap_pkg::*;

  state_e state_q, state_d;
  op_e    pc_q, pc_d;
  logic   out_vld_q, out_vld_d;
  logic   out_take;

  function automatic op_e next_op(op_e op);
    op_e n;
    unique case (op)
      OP_DIFF: n = OP_SQX;
      OP_SQX:  n = OP_SQY;
      OP_SQY:  n = OP_SQRT;
      OP_SQRT: n = OP_K1;
      OP_K1:   n = OP_K2;
      OP_K2:   n = OP_AX;
      OP_AX:   n = OP_DX1;
      OP_DX1:  n = OP_DX2;
      OP_DX2:  n = OP_DX3;
      OP_DX3:  n = OP_VX;
      OP_VX:   n = OP_AY;
      OP_AY:   n = OP_DY1;
      OP_DY1:  n = OP_DY2;
      OP_DY2:  n = OP_DY3;
      OP_DY3:  n = OP_VY;
      OP_FX:   n = OP_FY;
      OP_FY:   n = OP_PX;
      OP_PX:   n = OP_PY;
      default: n = OP_DIFF;
    endcase
    return n;
  endfunction

  assign out_take    = out_vld_q && !out_stall_i;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= OP_DIFF;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    cmd_o      = '0;
    cmd_o.op   = pc_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_mode_i == MODE_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.cur_valid) begin
          pc_d    = OP_DIFF;
          state_d = ST_ISSUE;
        end else if (sts_i.idx_last) begin
          pc_d    = OP_FX;
          state_d = ST_ISSUE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_ISSUE: begin
        // too close: the slot contributes nothing
        if (pc_q == OP_SQRT && sts_i.near) begin
          if (sts_i.idx_last) begin
            pc_d = OP_FX;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_SCAN;
          end
        end else begin
          cmd_o.start = 1'b1;
          state_d     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts_i.done) begin
          if (pc_q == OP_VY) begin
            if (sts_i.idx_last) begin
              pc_d    = OP_FX;
              state_d = ST_ISSUE;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = ST_SCAN;
            end
          end else if (pc_q == OP_PY) begin
            state_d = ST_DONE;
          end else begin
            pc_d    = next_op(pc_q);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_take) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_take) out_vld_d = 1'b0;
    if (cmd_o.publish) out_vld_d = 1'b1;
  end

endmodule

`default_nettype wire

// ===== hdl/pap_dp.sv =====
// ----------------------------------------------------------------------------
// pap_dp
// Datapath: attractor table, particle state, two-pass multiplier,
// bit-serial divider and digit-by-digit square root.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_dp #(
  parameter int MAX_ATTRACTORS = 16,
  parameter int FRAC_BITS      = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pap_pkg::pap_cmd_t  cmd_i,
  output pap_pkg::pap_sts_t       sts_o,
  input  wire pap_pkg::in_item_t  in_data_i,
  input  wire logic [16:0]        friction_i,
  input  wire logic [31:0]        gain_i,
  output pap_pkg::out_item_t      out_data_o
);
  import pap_pkg::*;

  localparam int AW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
  localparam int NW = MAG_W + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam logic [63:0] R2_LIMIT = 64'd4 << (2 * FRAC_BITS);

  // table
  logic [AW-1:0]             idx_q;
  logic [MAX_ATTRACTORS-1:0] vld_q;
  logic [SLOT_EW-1:0]        slot_w;
  logic                      slot_ok;
  logic                      tbl_we;
  logic [95:0]               rd_data;
  logic signed [31:0]        att_x, att_y, att_m;

  // particle and working registers
  logic signed [31:0] px_q, py_q, vx_q, vy_q, mp_q;
  logic [31:0]        inv_q;
  logic signed [32:0] dx_q, dy_q, ms_q;
  logic [63:0]        r2_q;
  logic [31:0]        r_q;
  logic signed [MAG_W:0] k_q, t_q;
  out_item_t          out_q;

  // sequencing
  op_e         op_q;
  logic        busy_q;
  logic [CW-1:0] cnt_q;
  logic        is_mul, is_div, is_sqrt, last;

  // multiplier
  logic [63:0]        mul_a;
  logic [32:0]        mul_b;
  logic               mul_neg;
  logic [64:0]        plo_c, phi_c;
  logic [64:0]        plo_q;
  logic [PROD_W-1:0]  prod_q;
  logic [MAG_W-1:0]   m_f, m_16;
  logic signed [MAG_W:0] sv_f, sv_16;
  logic [64:0]        r2_sum;

  // square root
  logic [63:0] rad_q;
  logic [33:0] srem_q;
  logic [31:0] root_q;
  logic [35:0] s_sh, s_trial;
  logic        s_ge;
  logic [35:0] s_diff;
  logic [31:0] root_n;

  // divider
  logic [NW-1:0] num_q, num_n;
  logic [31:0]   drem_q;
  logic          dneg_q;
  logic [32:0]   d_sh;
  logic          d_ge;
  logic [32:0]   d_diff;
  logic [MAG_W-1:0] q_sat;

  logic [32:0]   dx_mag, dy_mag, ms_mag;
  logic [MAG_W:0] k_mag, t_mag;
  logic [31:0]   vx_mag, vy_mag;

  assign slot_w  = SLOT_EW'(in_data_i.slot);
  assign slot_ok = slot_w < SLOT_EW'(MAX_ATTRACTORS);
  assign tbl_we  = cmd_i.load && slot_ok;

  pap_ram #(
    .WIDTH (96),
    .DEPTH (MAX_ATTRACTORS)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (slot_w[AW-1:0]),
    .wdata_i ({in_data_i.pos_x, in_data_i.pos_y, in_data_i.body_mass}),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign att_x = rd_data[95:64];
  assign att_y = rd_data[63:32];
  assign att_m = rd_data[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      idx_q  <= '0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_DIFF;
    end else begin
      if (tbl_we) vld_q[slot_w[AW-1:0]] <= in_data_i.slot_enable;
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + AW'(1);
      if (cmd_i.start) begin
        op_q   <= cmd_i.op;
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) busy_q <= 1'b0;
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  assign sts_o.cur_valid = vld_q[idx_q];
  assign sts_o.idx_last  = (idx_q == AW'(MAX_ATTRACTORS - 1));
  assign sts_o.near      = !(r2_q > R2_LIMIT);
  assign sts_o.done      = busy_q && last;

  always_comb begin
    is_mul  = 1'b0;
    is_div  = 1'b0;
    is_sqrt = 1'b0;
    case (op_q) inside
      OP_SQX, OP_SQY, OP_K1, OP_K2, OP_AX, OP_AY,
      OP_FX, OP_FY, OP_PX, OP_PY:                   is_mul  = 1'b1;
      OP_DX1, OP_DX2, OP_DX3, OP_DY1, OP_DY2, OP_DY3: is_div  = 1'b1;
      OP_SQRT:                                      is_sqrt = 1'b1;
      default: ;
    endcase
    if (is_mul) last = (cnt_q == CW'(2));
    else if (is_div) last = (cnt_q == CW'(NW - 1));
    else if (is_sqrt) last = (cnt_q == CW'(31));
    else last = 1'b1;
  end

  assign dx_mag = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign dy_mag = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
  assign ms_mag = ms_q[32] ? 33'(-ms_q) : 33'(ms_q);
  assign k_mag  = k_q[MAG_W] ? (MAG_W+1)'(-k_q) : (MAG_W+1)'(k_q);
  assign t_mag  = t_q[MAG_W] ? (MAG_W+1)'(-t_q) : (MAG_W+1)'(t_q);
  assign vx_mag = vx_q[31] ? 32'(-vx_q) : 32'(vx_q);
  assign vy_mag = vy_q[31] ? 32'(-vy_q) : 32'(vy_q);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (op_q)
      OP_SQX: begin mul_a = 64'(dx_mag); mul_b = dx_mag; end
      OP_SQY: begin mul_a = 64'(dy_mag); mul_b = dy_mag; end
      OP_K1: begin
        mul_a = 64'(gain_i); mul_b = ms_mag; mul_neg = ms_q[32];
      end
      OP_K2: begin
        mul_a = 64'(k_mag); mul_b = 33'(inv_q); mul_neg = k_q[MAG_W];
      end
      OP_AX: begin
        mul_a = 64'(k_mag); mul_b = dx_mag; mul_neg = k_q[MAG_W] ^ dx_q[32];
      end
      OP_AY: begin
        mul_a = 64'(k_mag); mul_b = dy_mag; mul_neg = k_q[MAG_W] ^ dy_q[32];
      end
      OP_FX: begin
        mul_a = 64'(vx_mag); mul_b = 33'(friction_i); mul_neg = vx_q[31];
      end
      OP_FY: begin
        mul_a = 64'(vy_mag); mul_b = 33'(friction_i); mul_neg = vy_q[31];
      end
      OP_PX: begin
        mul_a = 64'(vx_mag); mul_b = 33'(inv_q); mul_neg = vx_q[31];
      end
      OP_PY: begin
        mul_a = 64'(vy_mag); mul_b = 33'(inv_q); mul_neg = vy_q[31];
      end
      default: ;
    endcase
  end

  assign plo_c  = mul_a[31:0] * mul_b;
  assign phi_c  = mul_a[63:32] * mul_b;
  assign m_f    = sat62(prod_q >> FRAC_BITS);
  assign m_16   = sat62(prod_q >> FRIC_W);
  assign sv_f   = apply_sign(m_f, mul_neg);
  assign sv_16  = apply_sign(m_16, mul_neg);
  assign r2_sum = {1'b0, r2_q} + {1'b0, prod_q[63:0]};

  // digit-by-digit root: each step takes two radicand bits and adds one root bit
  assign s_sh    = {srem_q, rad_q[63:62]};
  assign s_trial = {2'b00, root_q, 2'b01};
  assign s_ge    = s_sh >= s_trial;
  assign s_diff  = s_sh - s_trial;
  assign root_n  = {root_q[30:0], s_ge};

  // restoring division, one quotient bit per cycle
  assign d_sh   = {drem_q, num_q[NW-1]};
  assign d_ge   = d_sh >= {1'b0, r_q};
  assign d_diff = d_sh - {1'b0, r_q};
  assign num_n  = {num_q[NW-2:0], d_ge};
  assign q_sat  = (|num_n[NW-1:MAG_W]) ? '1 : num_n[MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q  <= in_data_i.pos_x;
      py_q  <= in_data_i.pos_y;
      vx_q  <= in_data_i.vel_x;
      vy_q  <= in_data_i.vel_y;
      mp_q  <= in_data_i.body_mass;
      inv_q <= in_data_i.inv_elapsed;
    end
    if (cmd_i.publish) begin
      out_q.new_pos_x <= px_q;
      out_q.new_pos_y <= py_q;
      out_q.new_vel_x <= vx_q;
      out_q.new_vel_y <= vy_q;
    end
    if (cmd_i.start) begin
      rad_q  <= r2_q;
      srem_q <= '0;
      root_q <= '0;
      num_q  <= {t_mag[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      drem_q <= '0;
      dneg_q <= t_q[MAG_W];
    end else if (busy_q) begin
      if (is_sqrt) begin
        srem_q <= s_ge ? s_diff[33:0] : s_sh[33:0];
        root_q <= root_n;
        rad_q  <= {rad_q[61:0], 2'b00};
        if (last) r_q <= root_n;
      end
      if (is_div) begin
        drem_q <= d_ge ? d_diff[31:0] : d_sh[31:0];
        num_q  <= num_n;
        if (last) t_q <= apply_sign(q_sat, dneg_q);
      end
      if (is_mul) begin
        if (cnt_q == CW'(0)) plo_q <= plo_c;
        if (cnt_q == CW'(1)) prod_q <= {phi_c, 32'b0} + PROD_W'(plo_q);
      end
      if (last) begin
        case (op_q)
          OP_DIFF: begin
            dx_q <= 33'(att_x) - 33'(px_q);
            dy_q <= 33'(att_y) - 33'(py_q);
            ms_q <= 33'(att_m) + 33'(mp_q);
          end
          OP_SQX: r2_q <= prod_q[63:0];
          OP_SQY: r2_q <= r2_sum[64] ? '1 : r2_sum[63:0];
          OP_K1, OP_K2: k_q <= sv_f;
          OP_AX, OP_AY: t_q <= sv_f;
          OP_VX: vx_q <= sat32(64'(vx_q) + 64'(t_q));
          OP_VY: vy_q <= sat32(64'(vy_q) + 64'(t_q));
          OP_FX: vx_q <= sat32(64'(sv_16));
          OP_FY: vy_q <= sat32(64'(sv_16));
          OP_PX: px_q <= sat32(64'(px_q) + 64'(sv_f));
          OP_PY: py_q <= sat32(64'(py_q) + 64'(sv_f));
          default: ;
        endcase
      end
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== hdl/point_attractor_particle_step_core.sv =====
// ----------------------------------------------------------------------------
// point_attractor_particle_step_core
// Point attractor table and particle integrator, Q16.16 with saturation.
//
//   channel   direction  handshake             payload
//   in        input      in_valid_i/in_stall_o   pap_pkg::in_item_t
//   out       output     out_valid_o/out_stall_i pap_pkg::out_item_t
//   config    input      APB (psel/penable)    friction, gravity_gain
//
// A load transaction is taken in the idle state and gives no result.
// A step transaction scans the table and, for each valid slot in range,
// runs the square root, the multiplies and the bit-serial divider (three
// quotients per axis); a valid slot within two units stops before the
// square root. Friction and position updates close the step.
// Reset clears the slot valid bits and restores the register defaults.
// A finished result waits in the output register while the next
// transaction is accepted; a step result waits for it to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module point_attractor_particle_step_core #(
  parameter int MAX_ATTRACTORS = 16,
  parameter int FRAC_BITS      = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pap_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pap_pkg::out_item_t      out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import pap_pkg::*;

  localparam logic [31:0] GAIN_RESET = 32'((64'd667 << FRAC_BITS) / 1000);
  localparam logic        REG_FRICTION = 1'b0;
  localparam logic        REG_GAIN     = 1'b1;

  logic [16:0] friction_q;
  logic [31:0] gain_q;
  logic        cfg_wr;
  pap_cmd_t    cmd;
  pap_sts_t    sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      friction_q <= 17'd65536;
      gain_q     <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRICTION: friction_q <= pwdata[16:0];
        REG_GAIN:     gain_q     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRICTION: prdata = 32'(friction_q);
      REG_GAIN:     prdata = gain_q;
      default:      prdata = '0;
    endcase
  end

  pap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pap_dp #(
    .MAX_ATTRACTORS (MAX_ATTRACTORS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .friction_i (friction_q),
    .gain_i     (gain_q),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/pap_checker.sv =====
// ----------------------------------------------------------------------------
// pap_checker
// Port-level checks on the particle step core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire pap_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire pap_pkg::out_item_t out_data_o
);
  import pap_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a load transaction never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode == MODE_LOAD && !out_valid_o
    |=> !out_valid_o)
    else $error("load transaction produced a result");

  // a step transaction occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode == MODE_STEP |=> in_stall_o)
    else $error("input not stalled after step");

  // results only appear at the end of a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

bind point_attractor_particle_step_core pap_checker u_pap_checker (.*);

`default_nettype wire
